FILE: sv/iort_pkg.sv
// Package for the in-order range table.
// Holds the result status codes and the structs passed along the cell chain.
// No dependencies.
package iort_pkg;

  localparam logic [2:0] ST_ADDED     = 3'd0;
  localparam logic [2:0] ST_DUPLICATE = 3'd1;
  localparam logic [2:0] ST_OUT_ORDER = 3'd2;
  localparam logic [2:0] ST_FULL      = 3'd3;
  localparam logic [2:0] ST_LOOKUP    = 3'd4;

  localparam logic OP_APPEND = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  // Query travelling down the chain, one cell per cycle.
  typedef struct packed {
    logic        valid;
    logic [31:0] value;
    logic        found;
    logic [31:0] offset;
  } query_t;

  // Write broadcast to every cell; the cell with the matching index takes it.
  typedef struct packed {
    logic        open;
    logic        grow;
    logic [31:0] value;
  } cell_wr_t;

endpackage

FILE: sv/in_order_range_table.sv
// An append item passes from the S_APPEND state into the output register, and
// waits in S_APPEND while the output register still holds an unaccepted result.
// A lookup item walks down a row of MAX_RANGES cells, one cell per clock, and
// its result then waits in S_RESULT until the output register is free. One
// item is in work at a time, and a new item is taken while the previous result
// still waits at the output register. Lookups of values outside every stored
// range report not found with index and offset zero.
// Top level of the in-order range table; depends on iort_pkg and iort_cell.
module in_order_range_table #(
  parameter int MAX_RANGES = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_op,
  input  logic signed [31:0] in_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_status,
  output logic        out_range_found,
  output logic [7:0]  out_range_index,
  output logic [31:0] out_offset_in_range,
  output logic [32:0] out_element_total,
  output logic [8:0]  out_ranges_used
);

  localparam int IDX_W = $clog2(MAX_RANGES);
  localparam int CNT_W = $clog2(MAX_RANGES + 1);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_APPEND = 4'b0010,
    S_SEARCH = 4'b0100,
    S_RESULT = 4'b1000
  } state_t;

  state_t             state_r, state_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [32:0]        total_r, total_nxt;
  logic [31:0]        last_hi_r, last_hi_nxt;
  logic [31:0]        item_r;
  logic               hold_found_r;
  logic [IDX_W-1:0]   hold_idx_r;
  logic [31:0]        hold_off_r;

  logic               out_valid_r, out_valid_nxt;
  logic [2:0]         status_r, status_nxt;
  logic               found_r, found_nxt;
  logic [7:0]         index_r, index_nxt;
  logic [31:0]        off_r, off_nxt;
  logic [32:0]        total_out_r, total_out_nxt;
  logic [8:0]         used_r, used_nxt;

  iort_pkg::query_t   q_chain   [0:MAX_RANGES];
  logic [IDX_W-1:0]   idx_chain [0:MAX_RANGES];
  iort_pkg::cell_wr_t wr;
  logic [IDX_W-1:0]   wr_idx;

  logic               in_acc;
  logic               out_free;
  logic [31:0]        hold_idx_ext;
  logic [31:0]        used_ext;
  logic [CNT_W-1:0]   count_dec;

  assign in_ready  = (state_r == S_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;
  assign count_dec = count_r - CNT_W'(1);

  // A lookup enters the first cell in the cycle it is accepted.
  always_comb begin
    q_chain[0].valid  = in_acc && (in_op == iort_pkg::OP_LOOKUP);
    q_chain[0].value  = in_value;
    q_chain[0].found  = 1'b0;
    q_chain[0].offset = 32'd0;
    idx_chain[0]      = '0;
  end

  for (genvar i = 0; i < MAX_RANGES; i++) begin : g_cell
    iort_cell #(
      .IDX_W    (IDX_W),
      .CNT_W    (CNT_W),
      .CELL_IDX (i)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .count     (count_r),
      .wr        (wr),
      .wr_idx    (wr_idx),
      .q_in      (q_chain[i]),
      .q_idx_in  (idx_chain[i]),
      .q_out     (q_chain[i+1]),
      .q_idx_out (idx_chain[i+1])
    );
  end

  assign hold_idx_ext = 32'(hold_idx_r);

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    total_nxt     = total_r;
    last_hi_nxt   = last_hi_r;
    out_valid_nxt = out_valid_r && !out_ready;
    status_nxt    = status_r;
    found_nxt     = found_r;
    index_nxt     = index_r;
    off_nxt       = off_r;
    total_out_nxt = total_out_r;
    used_nxt      = used_r;
    wr.open       = 1'b0;
    wr.grow       = 1'b0;
    wr.value      = item_r;
    wr_idx        = count_r[IDX_W-1:0];
    used_ext      = 32'd0;

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (in_op == iort_pkg::OP_LOOKUP) begin
            state_nxt = S_SEARCH;
          end else begin
            state_nxt = S_APPEND;
          end
        end
      end
      S_APPEND: begin
        if (out_free) begin
          status_nxt = iort_pkg::ST_ADDED;
          if (count_r == '0) begin
            wr.open     = 1'b1;
            wr_idx      = '0;
            count_nxt   = CNT_W'(1);
            total_nxt   = total_r + 33'd1;
            last_hi_nxt = item_r;
          end else if ($signed(item_r) < $signed(last_hi_r)) begin
            status_nxt = iort_pkg::ST_OUT_ORDER;
          end else if (item_r == last_hi_r) begin
            status_nxt = iort_pkg::ST_DUPLICATE;
          end else if (item_r == last_hi_r + 32'd1) begin
            wr.grow     = 1'b1;
            wr_idx      = count_dec[IDX_W-1:0];
            total_nxt   = total_r + 33'd1;
            last_hi_nxt = item_r;
          end else if (count_r >= CNT_W'(MAX_RANGES)) begin
            status_nxt = iort_pkg::ST_FULL;
          end else begin
            wr.open     = 1'b1;
            wr_idx      = count_r[IDX_W-1:0];
            count_nxt   = count_r + CNT_W'(1);
            total_nxt   = total_r + 33'd1;
            last_hi_nxt = item_r;
          end
          used_ext      = 32'(count_nxt);
          out_valid_nxt = 1'b1;
          found_nxt     = 1'b0;
          index_nxt     = 8'd0;
          off_nxt       = 32'd0;
          total_out_nxt = total_nxt;
          used_nxt      = used_ext[8:0];
          state_nxt     = S_IDLE;
        end
      end
      S_SEARCH: begin
        if (q_chain[MAX_RANGES].valid) begin
          state_nxt = S_RESULT;
        end
      end
      S_RESULT: begin
        if (out_free) begin
          used_ext      = 32'(count_r);
          out_valid_nxt = 1'b1;
          status_nxt    = iort_pkg::ST_LOOKUP;
          found_nxt     = hold_found_r;
          index_nxt     = hold_found_r ? hold_idx_ext[7:0] : 8'd0;
          off_nxt       = hold_found_r ? hold_off_r : 32'd0;
          total_out_nxt = total_r;
          used_nxt      = used_ext[8:0];
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      total_r     <= 33'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      total_r     <= total_nxt;
      out_valid_r <= out_valid_nxt;
    end
    last_hi_r   <= last_hi_nxt;
    status_r    <= status_nxt;
    found_r     <= found_nxt;
    index_r     <= index_nxt;
    off_r       <= off_nxt;
    total_out_r <= total_out_nxt;
    used_r      <= used_nxt;
    if (in_acc) begin
      item_r <= in_value;
    end
    if (q_chain[MAX_RANGES].valid) begin
      hold_found_r <= q_chain[MAX_RANGES].found;
      hold_idx_r   <= idx_chain[MAX_RANGES];
      hold_off_r   <= q_chain[MAX_RANGES].offset;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_status          = status_r;
  assign out_range_found     = found_r;
  assign out_range_index     = index_r;
  assign out_offset_in_range = off_r;
  assign out_element_total   = total_out_r;
  assign out_ranges_used     = used_r;

endmodule

FILE: sv/iort_cell.sv
// One cell of the range chain: stores one range and checks passing queries.
// Depends on iort_pkg for the query and write structs.
module iort_cell #(
  parameter int IDX_W    = 8,
  parameter int CNT_W    = 9,
  parameter int CELL_IDX = 0
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [CNT_W-1:0]     count,
  input  iort_pkg::cell_wr_t   wr,
  input  logic [IDX_W-1:0]     wr_idx,
  input  iort_pkg::query_t     q_in,
  input  logic [IDX_W-1:0]     q_idx_in,
  output iort_pkg::query_t     q_out,
  output logic [IDX_W-1:0]     q_idx_out
);

  logic [31:0]       low_r;
  logic [31:0]       high_r;
  iort_pkg::query_t  q_r;
  iort_pkg::query_t  q_nxt;
  logic [IDX_W-1:0]  idx_r;
  logic [IDX_W-1:0]  idx_nxt;
  logic              sel;
  logic              live;
  logic              hit;

  assign sel  = (wr_idx == IDX_W'(CELL_IDX));
  assign live = (count > CNT_W'(CELL_IDX));
  assign hit  = q_in.valid && !q_in.found && live &&
                ($signed(q_in.value) >= $signed(low_r)) &&
                ($signed(q_in.value) <= $signed(high_r));

  always_ff @(posedge clk) begin
    if (wr.open && sel) begin
      low_r  <= wr.value;
      high_r <= wr.value;
    end else if (wr.grow && sel) begin
      high_r <= wr.value;
    end
  end

  always_comb begin
    q_nxt   = q_in;
    idx_nxt = q_idx_in;
    if (hit) begin
      q_nxt.found  = 1'b1;
      q_nxt.offset = q_in.value - low_r;
      idx_nxt      = IDX_W'(CELL_IDX);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r.valid <= 1'b0;
    end else begin
      q_r.valid <= q_nxt.valid;
    end
    q_r.value  <= q_nxt.value;
    q_r.found  <= q_nxt.found;
    q_r.offset <= q_nxt.offset;
    idx_r      <= idx_nxt;
  end

  assign q_out     = q_r;
  assign q_idx_out = idx_r;

endmodule
